// File: hw/rtl/line_substring_filter_core_assert.svh
// Assertion helpers for the line substring filter core.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH

// Same-cycle implication
`define LSF_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define LSF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/lsf_pkg.sv
package lsf_pkg;

  // Default sizes
  localparam int unsigned PatternMaxDefault  = 16;
  localparam int unsigned CounterBitsDefault = 24;

  // Fixed field and register widths
  localparam int unsigned PatternBits  = 128;
  localparam int unsigned LenBits      = 5;
  localparam int unsigned OutCountBits = 24;
  localparam int unsigned AddrBits     = 6;
  localparam int unsigned DataBits     = 64;

  // Input operation codes
  typedef enum logic [1:0] {
    OpByte = 2'd0,
    OpEol  = 2'd1,
    OpEos  = 2'd2
  } lsf_op_e;

  // Register indexes (byte address / 8)
  typedef enum logic [2:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegPatternLength = 3'd2,
    RegCaseFold      = 3'd3,
    RegInvert        = 3'd4,
    RegReportMode    = 3'd5
  } lsf_reg_e;

  // Report modes
  typedef enum logic [1:0] {
    ModeList     = 2'd0,
    ModeNumbered = 2'd1,
    ModeCount    = 2'd2
  } lsf_mode_e;

  // Result kinds
  localparam logic KindLine  = 1'b0;
  localparam logic KindFinal = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] text_byte;
  } lsf_in_t;

  typedef struct packed {
    logic                    kind;
    logic [OutCountBits-1:0] line_number;
    logic [OutCountBits-1:0] selected_count;
    logic                    none_found;
  } lsf_out_t;

  // Control shared by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } lsf_cell_ctrl_t;

endpackage

// File: hw/rtl/lsf_cell.sv
module lsf_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsf_pkg::lsf_cell_ctrl_t ctrl_i,
  input  logic [7:0]             byte_i,
  input  logic                   valid_i,
  input  logic [7:0]             pat_i,
  input  logic                   use_i,
  output logic [7:0]             byte_o,
  output logic                   valid_o,
  output logic                   match_o
);
  import lsf_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q;

  // Lower ASCII capitals when folding is on
  function automatic logic [7:0] fold_byte(logic [7:0] c, logic en);
    if (en && c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Compare the byte arriving from the neighbor with this cell's pattern byte
  assign match_o = !use_i ||
                   (valid_i && fold_byte(byte_i, ctrl_i.fold) == fold_byte(pat_i, ctrl_i.fold));

  // Advance or drop the valid mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  // Advance the byte
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: hw/rtl/lsf_window.sv
module lsf_window #(
  parameter int unsigned PatternMax = lsf_pkg::PatternMaxDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lsf_pkg::lsf_cell_ctrl_t          ctrl_i,
  input  logic [7:0]                       byte_i,
  input  logic [lsf_pkg::PatternBits-1:0]  pattern_i,
  input  logic [lsf_pkg::LenBits-1:0]      len_i,
  output logic                             hit_o
);
  import lsf_pkg::*;

  localparam logic [LenBits-1:0] LenMax = LenBits'(PatternMax);

  logic [LenBits-1:0]    len_eff;
  logic [7:0]            cell_byte [PatternMax];
  logic                  cell_valid [PatternMax];
  logic [PatternMax-1:0] cell_match;

  // Clamp an overlong length
  assign len_eff = (len_i > LenMax) ? LenMax : len_i;

  // Row of cells; cell k holds the k-th most recent byte of the line
  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    localparam logic [LenBits-1:0] Pos = LenBits'(k);
    logic [LenBits-1:0] pat_idx;
    logic [7:0]         pat_byte;
    logic [7:0]         in_byte;
    logic               in_valid;

    // Pattern byte that lines up with this cell: index len - 1 - k
    assign pat_idx  = len_eff - Pos - LenBits'(1);
    assign pat_byte = pattern_i[{pat_idx[3:0], 3'b000} +: 8];

    if (k == 0) begin : g_head
      assign in_byte  = byte_i;
      assign in_valid = 1'b1;
    end else begin : g_body
      assign in_byte  = cell_byte[k-1];
      assign in_valid = cell_valid[k-1];
    end

    lsf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .byte_i  (in_byte),
      .valid_i (in_valid),
      .pat_i   (pat_byte),
      .use_i   (Pos < len_eff),
      .byte_o  (cell_byte[k]),
      .valid_o (cell_valid[k]),
      .match_o (cell_match[k])
    );
  end

  // Hit on the window as it stands after this byte
  assign hit_o = (len_eff != '0) && (&cell_match);

endmodule

// File: hw/rtl/line_substring_filter_core.sv
// Fixed-string line filter. Text arrives as transfers of one byte, end of line or end of
// stream; the block takes one transfer per clock unless the output buffer is full, and each
// result is registered into the output buffer. A row of PatternMax byte cells shifts
// each text byte in and compares every pattern position in the same cycle, which sets the
// one-byte-per-clock figure. A two-entry output buffer keeps the input open while a result
// waits. Configuration is a 64-bit APB-style port (register i at byte address 8*i); the user
// must write it only while the stream is idle, and the block itself does not enforce this.
`include "line_substring_filter_core_assert.svh"

module line_substring_filter_core #(
  parameter int unsigned PatternMax  = lsf_pkg::PatternMaxDefault,
  parameter int unsigned CounterBits = lsf_pkg::CounterBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lsf_pkg::lsf_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lsf_pkg::lsf_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsf_pkg::AddrBits-1:0]   paddr,
  input  logic [lsf_pkg::DataBits-1:0]   pwdata,
  output logic [lsf_pkg::DataBits-1:0]   prdata,
  output logic                           pready
);
  import lsf_pkg::*;

  localparam logic [CounterBits-1:0] CountOne = CounterBits'(1);

  // Configuration registers
  logic [63:0]        pat_lo_q, pat_hi_q;
  logic [LenBits-1:0] len_q;
  logic               fold_q, invert_q;
  logic [1:0]         mode_q;
  lsf_reg_e           reg_idx;
  logic               cfg_wr;

  // Stream state
  logic                   line_match_q, line_match_d;
  logic [CounterBits-1:0] line_cnt_q, line_cnt_d;
  logic [CounterBits-1:0] sel_cnt_q, sel_cnt_d;

  // Datapath control
  logic           accept, hit, listing, push;
  lsf_cell_ctrl_t cell_ctrl;
  lsf_out_t       result;
  logic [31:0]    line_wide, sel_wide, sel_q_wide;

  // Output buffer
  logic     out_valid_q, skid_valid_q, pop;
  lsf_out_t out_q, skid_q;

  // Configuration writes and reads
  assign reg_idx = lsf_reg_e'(paddr[AddrBits-1:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      fold_q   <= 1'b0;
      invert_q <= 1'b0;
      mode_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPatternLow:    pat_lo_q <= pwdata;
        RegPatternHigh:   pat_hi_q <= pwdata;
        RegPatternLength: len_q    <= pwdata[LenBits-1:0];
        RegCaseFold:      fold_q   <= pwdata[0];
        RegInvert:        invert_q <= pwdata[0];
        RegReportMode:    mode_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPatternLow:    prdata = pat_lo_q;
      RegPatternHigh:   prdata = pat_hi_q;
      RegPatternLength: prdata = DataBits'(len_q);
      RegCaseFold:      prdata = DataBits'(fold_q);
      RegInvert:        prdata = DataBits'(invert_q);
      RegReportMode:    prdata = DataBits'(mode_q);
      default:          prdata = '0;
    endcase
  end

  // Shift window of cells
  assign cell_ctrl.shift = accept && (in_data_i.op == OpByte);
  assign cell_ctrl.clear = accept && (in_data_i.op == OpEol || in_data_i.op == OpEos);
  assign cell_ctrl.fold  = fold_q;

  lsf_window #(
    .PatternMax (PatternMax)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cell_ctrl),
    .byte_i    (in_data_i.text_byte),
    .pattern_i ({pat_hi_q, pat_lo_q}),
    .len_i     (len_q),
    .hit_o     (hit)
  );

  // Per-transfer line and stream bookkeeping
  assign accept     = in_valid_i && in_ready_o;
  assign listing    = (mode_q == ModeList) || (mode_q == ModeNumbered);
  assign line_wide  = 32'(line_cnt_d);
  assign sel_wide   = 32'(sel_cnt_d);
  assign sel_q_wide = 32'(sel_cnt_q);

  always_comb begin
    line_match_d = line_match_q;
    line_cnt_d   = line_cnt_q;
    sel_cnt_d    = sel_cnt_q;
    push         = 1'b0;
    result       = '0;
    if (accept) begin
      unique case (in_data_i.op)
        OpByte: begin
          if (hit) begin
            line_match_d = 1'b1;
          end
        end
        OpEol: begin
          line_match_d = 1'b0;
          line_cnt_d   = (line_cnt_q == '1) ? line_cnt_q : line_cnt_q + CountOne;
          if (line_match_q ^ invert_q) begin
            sel_cnt_d = (sel_cnt_q == '1) ? sel_cnt_q : sel_cnt_q + CountOne;
            if (listing) begin
              push                  = 1'b1;
              result.kind           = KindLine;
              result.line_number    = line_wide[OutCountBits-1:0];
              result.selected_count = sel_wide[OutCountBits-1:0];
            end
          end
        end
        OpEos: begin
          line_match_d          = 1'b0;
          line_cnt_d            = '0;
          sel_cnt_d             = '0;
          push                  = 1'b1;
          result.kind           = KindFinal;
          result.selected_count = sel_q_wide[OutCountBits-1:0];
          result.none_found     = (sel_cnt_q == '0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_match_q <= 1'b0;
      line_cnt_q   <= '0;
      sel_cnt_q    <= '0;
    end else begin
      line_match_q <= line_match_d;
      line_cnt_q   <= line_cnt_d;
      sel_cnt_q    <= sel_cnt_d;
    end
  end

  // Output register with skid entry; hold input only when the skid entry is full
  assign in_ready_o = !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `LSF_ASSERT_IMP(SkidNeedsOut_A, skid_valid_q, out_valid_q, "skid entry full with output empty")
  `LSF_ASSERT_NEXT(EosReports_A, accept && in_data_i.op == OpEos, out_valid_q, "end of stream gave no report")
  `LSF_ASSERT_NEXT(EosClears_A, accept && in_data_i.op == OpEos, line_cnt_q == '0 && sel_cnt_q == '0 && !line_match_q, "stream state not cleared")
  `LSF_ASSERT_IMP(SelBelowLines_A, 1'b1, sel_cnt_q <= line_cnt_q, "more lines selected than seen")

endmodule
